// ===== hdl/apu_pkg.sv =====
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types, character codes and helpers for the address prefix parser.
// ----------------------------------------------------------------------------
package apu_pkg;

    // numeric limits
    localparam int unsigned FieldW   = 16;
    localparam int unsigned NumField = 4;
    localparam int unsigned SumW     = FieldW + 4;

    // character codes
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_DOT   = 8'h2E;

    // number index
    localparam logic [1:0] LVL_ZONE  = 2'd0;
    localparam logic [1:0] LVL_NET   = 2'd1;
    localparam logic [1:0] LVL_NODE  = 2'd2;
    localparam logic [1:0] LVL_POINT = 2'd3;

    // parser phase
    typedef enum logic [1:0] {
        PH_LEAD,
        PH_NUM,
        PH_SEP,
        PH_TRAIL
    } t_phase;

    // input item
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_code;
        logic       last;
    } t_in_item;

    // result item
    typedef struct packed {
        logic              valid_res;
        logic [2:0]        depth;
        logic [FieldW-1:0] zone;
        logic [FieldW-1:0] net;
        logic [FieldW-1:0] node;
        logic [FieldW-1:0] point;
    } t_out_item;

    // character class
    typedef struct packed {
        logic       is_blank;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_colon;
        logic       is_slash;
        logic       is_dot;
    } t_char_class;

    // separator that may follow the number at this level
    function automatic logic sep_match(input logic [1:0] lvl, input t_char_class cls);
        logic hit;
        case (lvl)
            LVL_ZONE: hit = cls.is_colon;
            LVL_NET:  hit = cls.is_slash;
            LVL_NODE: hit = cls.is_dot;
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== hdl/apu_char_class.sv =====
// ----------------------------------------------------------------------------
// apu_char_class
// Sorts one byte into blank, digit and separator classes.
// ----------------------------------------------------------------------------
module apu_char_class
    import apu_pkg::*;
(
    input  logic [7:0]  i_char_code,
    output t_char_class o_cls
);

    // blanks are space and tab through carriage return
    always_comb begin
        o_cls.is_blank = (i_char_code == CHR_SPACE) ||
                         ((i_char_code >= CHR_TAB) && (i_char_code <= CHR_CR));
        o_cls.is_digit = (i_char_code >= CHR_ZERO) && (i_char_code <= CHR_NINE);
        // low nibble of an ascii digit is its value
        o_cls.digit    = i_char_code[3:0];
        o_cls.is_colon = (i_char_code == CHR_COLON);
        o_cls.is_slash = (i_char_code == CHR_SLASH);
        o_cls.is_dot   = (i_char_code == CHR_DOT);
    end

endmodule

// ===== hdl/apu_parser.sv =====
// ----------------------------------------------------------------------------
// apu_parser
// Parse state and its single-pass update for one character, result on last.
// ----------------------------------------------------------------------------
module apu_parser
    import apu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_has_char,
    input  logic        i_last,
    input  t_char_class i_cls,
    output t_out_item   o_res
);

    t_phase            r_phase, n_phase, u_phase;
    logic [1:0]        r_level, n_level, u_level;
    logic [FieldW-1:0] r_acc, n_acc, u_acc;
    logic [FieldW-1:0] r_fields [NumField];
    logic [FieldW-1:0] n_fields [NumField];
    logic [FieldW-1:0] u_fields [NumField];
    logic [2:0]        r_nread, n_nread, u_nread;
    logic              r_failed, n_failed, u_failed;

    logic [FieldW-1:0] acc_base;
    logic [SumW-1:0]   acc_sum;
    logic              acc_ovf;
    logic              ok;

    // decimal accumulate: base * 10 + digit
    always_comb begin
        acc_base = (r_phase == PH_NUM) ? r_acc : '0;
        acc_sum  = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1)
                 + {{(SumW-4){1'b0}}, i_cls.digit};
        acc_ovf  = (acc_sum[SumW-1:FieldW] != '0);
    end

    // character step
    always_comb begin
        u_phase  = r_phase;
        u_level  = r_level;
        u_acc    = r_acc;
        u_fields = r_fields;
        u_nread  = r_nread;
        u_failed = r_failed;
        if (i_has_char && !r_failed) begin
            case (r_phase)
                PH_LEAD, PH_SEP: begin
                    if (i_cls.is_digit) begin
                        // start a new number
                        u_phase = PH_NUM;
                        u_nread = {1'b0, r_level} + 3'd1;
                        if (acc_ovf) begin
                            u_failed = 1'b1;
                        end else begin
                            u_acc             = acc_sum[FieldW-1:0];
                            u_fields[r_level] = acc_sum[FieldW-1:0];
                        end
                    end else if (i_cls.is_blank) begin
                        if (r_phase == PH_SEP) begin
                            u_phase = PH_TRAIL;
                        end
                    end else begin
                        u_failed = 1'b1;
                    end
                end
                PH_NUM: begin
                    if (i_cls.is_digit) begin
                        if (acc_ovf) begin
                            u_failed = 1'b1;
                        end else begin
                            u_acc             = acc_sum[FieldW-1:0];
                            u_fields[r_level] = acc_sum[FieldW-1:0];
                        end
                    end else if (i_cls.is_blank) begin
                        u_phase = PH_TRAIL;
                    end else if (sep_match(r_level, i_cls)) begin
                        u_level = r_level + 2'd1;
                        u_acc   = '0;
                        u_phase = PH_SEP;
                    end else begin
                        u_failed = 1'b1;
                    end
                end
                default: begin
                    if (!i_cls.is_blank) begin
                        u_failed = 1'b1;
                    end
                end
            endcase
        end
    end

    // result of the text so far
    always_comb begin
        ok              = !u_failed && (u_nread != 3'd0);
        o_res.valid_res = ok;
        o_res.depth     = ok ? u_nread : 3'd0;
        o_res.zone      = ok ? u_fields[LVL_ZONE]  : '0;
        o_res.net       = ok ? u_fields[LVL_NET]   : '0;
        o_res.node      = ok ? u_fields[LVL_NODE]  : '0;
        o_res.point     = ok ? u_fields[LVL_POINT] : '0;
    end

    // next state: hold when idle, clear after the last item
    always_comb begin
        n_phase  = r_phase;
        n_level  = r_level;
        n_acc    = r_acc;
        n_fields = r_fields;
        n_nread  = r_nread;
        n_failed = r_failed;
        if (i_go) begin
            if (i_last) begin
                n_phase  = PH_LEAD;
                n_level  = '0;
                n_acc    = '0;
                n_fields = '{default: '0};
                n_nread  = '0;
                n_failed = 1'b0;
            end else begin
                n_phase  = u_phase;
                n_level  = u_level;
                n_acc    = u_acc;
                n_fields = u_fields;
                n_nread  = u_nread;
                n_failed = u_failed;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_level  <= '0;
            r_acc    <= '0;
            r_fields <= '{default: '0};
            r_nread  <= '0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_acc    <= n_acc;
            r_fields <= n_fields;
            r_nread  <= n_nread;
            r_failed <= n_failed;
        end
    end

endmodule

// ===== hdl/address_prefix_parser_unit.sv =====
// ----------------------------------------------------------------------------
// address_prefix_parser_unit
// Streaming parser of a zone:net/node.point address prefix, one char per item.
// ----------------------------------------------------------------------------
// result path: a last item passes the input register, and its result is then
//   registered in the output register, where it waits until it is taken
// throughput: one item per cycle; the input stage holds only while it holds a
//   last item and a stalled result still waits in the output register
// reset: synchronous active low, clears the parse state and both valid flags
// ----------------------------------------------------------------------------
module address_prefix_parser_unit
    import apu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        proc_go;
    logic        out_take;
    t_char_class cls;
    t_out_item   res;

    // process the held item unless its result has nowhere to go
    assign out_take   = r_out_valid && !i_out_stall;
    assign proc_go    = r_in_valid && (!r_in.last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    apu_char_class u_cls (
        .i_char_code (r_in.char_code),
        .o_cls       (cls)
    );

    apu_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (proc_go),
        .i_has_char (r_in.has_char),
        .i_last     (r_in.last),
        .i_cls      (cls),
        .o_res      (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_in.last) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a valid result always carries a depth, an invalid one never
    a_depth_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_res == (o_out_data.depth != 3'd0)))
        else $error("result depth disagrees with valid_res");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.depth <= 3'd4))
        else $error("result depth above four");

    // input side stalls only when its stage holds an item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty stage");

    // a processed last item always lands in the result register
    a_last_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && r_in.last) |=> o_out_valid)
        else $error("last item produced no result");

endmodule
